// ===== design/worst_fit_block_allocator_assert.svh =====
// Assertion macros for the worst-fit block allocator.
`ifndef WORST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define WFBA_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define WFBA_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WFBA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wfba_pkg.sv =====
`timescale 1ns / 1ps

package wfba_pkg;

    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_ADD     = 2'd1;
    localparam logic [1:0] ACT_REQUEST = 2'd2;

    localparam logic [2:0] ST_CLEARED = 3'd0;
    localparam logic [2:0] ST_ADDED   = 3'd1;
    localparam logic [2:0] ST_GRANTED = 3'd2;
    localparam logic [2:0] ST_NOFIT   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] item_size;
    } wfba_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] block_index;
    } wfba_result_t;

endpackage

// ===== design/worst_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// Channel   Signals              Direction  Handshake
// item      start, busy, item    in         accepted when start && !busy
// result    done, result         out        one-cycle strobe, no backpressure
//
// Clear and add need no scan; done rises the cycle after the request.
// An allocation request scans the size memory one entry per cycle through its
// single read port, then passes through the drain and decide states (an empty
// table goes straight to decide), busy high meanwhile.
// Reset clears the count and all taken flags; the size memory holds no reset.
// Results cannot be stalled: each done pulse lasts exactly one cycle.
module worst_fit_block_allocator
    import wfba_pkg::*;
#(
    parameter int MAX_BLOCKS = 32,
    parameter int SIZE_BITS  = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  wfba_item_t   item,
    output logic         done,
    output wfba_result_t result
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_DECIDE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [MAX_BLOCKS-1:0]  taken_reg, taken_next;
    logic [IDX_W-1:0]       rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0]       last_reg, last_next;
    logic [SIZE_BITS-1:0]   req_size_reg, req_size_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]       pipe_idx_reg, pipe_idx_next;
    logic                   pipe_taken_reg, pipe_taken_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0]   best_size_reg, best_size_next;
    logic                   done_reg, done_next;
    wfba_result_t           result_reg, result_next;

    logic [SIZE_BITS-1:0]   mem [MAX_BLOCKS];
    logic [SIZE_BITS-1:0]   rd_data_reg;
    logic                   mem_we;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_waddr;
    logic [SIZE_BITS-1:0]   mem_wdata;

    // Writes happen only in idle and reads only while scanning, so the two
    // ports never touch the same entry in one cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        taken_next      = taken_reg;
        rd_addr_next    = rd_addr_reg;
        last_next       = last_reg;
        req_size_next   = req_size_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        pipe_taken_next = pipe_taken_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_size_next  = best_size_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = count_reg[IDX_W-1:0];
        mem_wdata       = SIZE_BITS'(item.item_size);

        // Keep the largest free entry; strict compare leaves ties to the lower index.
        if (pipe_vld_reg && !pipe_taken_reg && (!found_reg || best_size_reg < rd_data_reg))
        begin
            found_next     = 1'b1;
            best_idx_next  = pipe_idx_reg;
            best_size_next = rd_data_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (item.action)
                        ACT_CLEAR:
                        begin
                            count_next  = '0;
                            taken_next  = '0;
                            done_next   = 1'b1;
                            result_next = '{status: ST_CLEARED, block_index: 5'd0};
                        end
                        ACT_ADD:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CNT_W'(MAX_BLOCKS))
                            begin
                                result_next = '{status: ST_FULL, block_index: 5'd0};
                            end
                            else
                            begin
                                mem_we                 = 1'b1;
                                taken_next[mem_waddr]  = 1'b0;
                                count_next             = count_reg + CNT_W'(1);
                                result_next = '{status: ST_ADDED, block_index: 5'(count_reg)};
                            end
                        end
                        ACT_REQUEST:
                        begin
                            req_size_next = SIZE_BITS'(item.item_size);
                            found_next    = 1'b0;
                            rd_addr_next  = '0;
                            last_next     = IDX_W'(count_reg - CNT_W'(1));
                            if (count_reg == '0)
                            begin
                                state_next = S_DECIDE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // drop unused action code
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                mem_re          = 1'b1;
                pipe_vld_next   = 1'b1;
                pipe_idx_next   = rd_addr_reg;
                pipe_taken_next = taken_reg[rd_addr_reg];
                if (rd_addr_reg == last_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                // last read data is compared this cycle
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (found_reg && best_size_reg >= req_size_reg)
                begin
                    taken_next[best_idx_reg] = 1'b1;
                    result_next = '{status: ST_GRANTED, block_index: 5'(best_idx_reg)};
                end
                else
                begin
                    result_next = '{status: ST_NOFIT, block_index: 5'd0};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            taken_reg    <= '0;
            pipe_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            taken_reg    <= taken_next;
            pipe_vld_reg <= pipe_vld_next;
            found_reg    <= found_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= rd_addr_next;
        last_reg       <= last_next;
        req_size_reg   <= req_size_next;
        pipe_idx_reg   <= pipe_idx_next;
        pipe_taken_reg <= pipe_taken_next;
        best_idx_reg   <= best_idx_next;
        best_size_reg  <= best_size_next;
        result_reg     <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`include "worst_fit_block_allocator_assert.svh"

    `WFBA_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_BLOCKS), "block count past table size")
    `WFBA_ASSERT_IMPLY(a_scan_addr, clk, rst_n, state_reg == S_SCAN, rd_addr_reg <= last_reg, "scan address past last entry")
    `WFBA_ASSERT_IMPLY(a_grant_taken, clk, rst_n, done_reg && result_reg.status == ST_GRANTED, taken_reg[best_idx_reg], "granted block not marked taken")
    `WFBA_ASSERT_NEXT(a_decide_done, clk, rst_n, state_reg == S_DECIDE, done_reg && !busy, "request finished without result")

endmodule
